/* src/bm3_pkg.sv */
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared types and constants for the 3x3 binary morphology block.
// ----------------------------------------------------------------------------
package bm3_pkg;

    localparam int PIX_W      = 8;
    localparam int MASK_W     = 9;
    localparam int HEIGHT_W   = 12;
    localparam int ROW_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [PIX_W-1:0]  FG_VALUE   = 8'd255;
    localparam logic [MASK_W-1:0] COL_KEEP   = 9'h0DB;
    localparam logic [MASK_W-1:0] MASK_RESET = 9'd186;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
    localparam int WIDTH_RESET = 640;
    localparam int MIN_SIZE    = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

    typedef enum logic [1:0] {
        MODE_ERODE  = 2'd0,
        MODE_DILATE = 2'd1,
        MODE_OPEN   = 2'd2,
        MODE_CLOSE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        SEQ_RUN,
        SEQ_GO1,
        SEQ_WAIT1,
        SEQ_GO2,
        SEQ_WAIT2
    } t_seq_state;

    // stage decision made when an item is accepted
    typedef struct packed {
        logic take;
        logic emit;
    } t_stage_acc;

    // stage result in the cycle the item is processed
    typedef struct packed {
        logic emit;
        logic last;
        logic bit_val;
    } t_stage_res;

endpackage

/* src/bm3_ram.sv */
// ----------------------------------------------------------------------------
// bm3_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bm3_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/bm3_div.sv */
// ----------------------------------------------------------------------------
// bm3_div
// Restoring divider, one quotient bit per cycle. Used to rebuild the
// row and column of a stage position after a frame size change.
// ----------------------------------------------------------------------------
module bm3_div #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quot,
    output logic [DIVISOR_W-1:0]  o_rem
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quot;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [CNT_W-1:0]      r_count;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign trial = {r_rem, r_quot[DIVIDEND_W-1]};
    assign ge    = (trial >= {1'b0, i_divisor});
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIVIDEND_W-2:0], ge};
            r_rem  <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

/* src/bm3_stage.sv */
// ----------------------------------------------------------------------------
// bm3_stage
// One 3x3 morphology stage: position counters, two line buffers in one
// RAM, the 3x3 window and the erode/dilate decision with border forcing.
// ----------------------------------------------------------------------------
module bm3_stage
    import bm3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int PW = CW + ROW_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [WW-1:0]       i_width,
    input  logic [HEIGHT_W-1:0] i_height,
    // accept side
    input  logic                i_capture,
    input  logic                i_offer,
    input  logic                i_restart,
    output t_stage_acc          o_acc,
    // position rebuild
    input  logic                i_load,
    input  logic [PW-1:0]       i_load_quot,
    input  logic [WW-1:0]       i_load_rem,
    output logic [PW-1:0]       o_pos,
    // processing side
    input  logic                i_fire,
    input  logic                i_bit,
    input  logic                i_erode,
    input  logic [MASK_W-1:0]   i_mask,
    output t_stage_res          o_res
);

    logic [PW-1:0]     r_pos;
    logic [ROW_W-1:0]  r_row;
    logic [CW-1:0]     r_col;
    logic [PW-1:0]     b_pos;
    logic [ROW_W-1:0]  b_row;
    logic [CW-1:0]     b_col;
    logic [PW-1:0]     n_pos;
    logic [ROW_W-1:0]  n_row;
    logic [CW-1:0]     n_col;
    logic [ROW_W-1:0]  h1;
    logic [ROW_W-1:0]  qr;
    logic [CW-1:0]     qc;
    logic [CW-1:0]     w_last;
    logic              take;
    logic              emit;
    logic              border;
    logic              last;
    logic              col_wrap;
    logic [ROW_W-1:0]  load_row;

    logic              r_push;
    logic              r_emit;
    logic              r_border;
    logic              r_last;
    logic              r_restart;
    logic [CW-1:0]     r_col_s;
    logic [MASK_W-1:0] r_win;
    logic [MASK_W-1:0] base_win;
    logic [MASK_W-1:0] n_win;
    logic [MASK_W-1:0] hit;
    logic [1:0]        rd_data;

    // position as seen by this item, counters restart on frame start
    assign b_pos = i_restart ? '0 : r_pos;
    assign b_row = i_restart ? '0 : r_row;
    assign b_col = i_restart ? '0 : r_col;

    assign h1     = ROW_W'(i_height) + ROW_W'(1);
    assign w_last = CW'(i_width - WW'(1));

    always_comb begin
        take   = !((b_row > h1) || ((b_row == h1) && (b_col != '0)));
        emit   = take && ((b_row >= ROW_W'(2)) || ((b_row == ROW_W'(1)) && (b_col != '0)));
        // output pixel sits one row and one column behind the input
        qc     = (b_col != '0) ? (b_col - CW'(1)) : w_last;
        qr     = (b_col != '0) ? (b_row - ROW_W'(1)) : (b_row - ROW_W'(2));
        border = (qr == '0) || (qr >= (h1 - ROW_W'(2))) || (qc == '0) || (qc == w_last);
        last   = (b_row == h1) && (b_col == '0);

        col_wrap = ((WW'(b_col) + WW'(1)) == i_width);
        n_pos = b_pos;
        n_row = b_row;
        n_col = b_col;
        if (i_offer && take) begin
            n_pos = b_pos + PW'(1);
            if (col_wrap) begin
                n_col = '0;
                n_row = b_row + ROW_W'(1);
            end else begin
                n_col = b_col + CW'(1);
            end
        end
    end

    assign o_acc.take = take;
    assign o_acc.emit = emit;

    // rows past the end of the frame collapse into one stopped value
    assign load_row = (i_load_quot > PW'(h1)) ? (h1 + ROW_W'(1)) : i_load_quot[ROW_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_row <= '0;
            r_col <= '0;
        end else if (i_load) begin
            r_row <= load_row;
            r_col <= i_load_rem[CW-1:0];
        end else if (i_capture) begin
            r_pos <= n_pos;
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign o_pos = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push    <= 1'b0;
            r_emit    <= 1'b0;
            r_restart <= 1'b0;
        end else if (i_capture) begin
            r_push    <= i_offer && take;
            r_emit    <= i_offer && emit;
            r_restart <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_border <= border;
            r_last   <= last;
            r_col_s  <= b_col;
        end
    end

    // entry holds {older line, newer line} for one column
    bm3_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk     (i_clk),
        .i_wr_en   (i_fire && r_push),
        .i_wr_addr (r_col_s),
        .i_wr_data ({rd_data[0], i_bit}),
        .i_rd_en   (i_capture && i_offer && take),
        .i_rd_addr (b_col),
        .o_rd_data (rd_data)
    );

    assign base_win = r_restart ? '0 : r_win;
    assign n_win    = ((base_win >> 1) & COL_KEEP)
                    | {i_bit, 2'b00, rd_data[0], 2'b00, rd_data[1], 2'b00};
    assign hit      = n_win & i_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_fire) begin
            r_win <= r_push ? n_win : base_win;
        end
    end

    assign o_res.emit    = r_emit;
    assign o_res.last    = r_last;
    assign o_res.bit_val = !r_border && (i_erode ? (hit == i_mask) : (hit != '0));

endmodule

/* src/binary_morphology_3x3.sv */
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// Streaming 3x3 binary erosion, dilation, opening and closing.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) takes one raster-order pixel per
// transaction with frame_start and flush flags; a pixel is foreground only
// at 255. Output channel (o_out_valid / i_out_stall) returns 0 or 255 with
// last_pixel on the final pixel of the frame. Each stage delays the stream
// by frame_width+1 items, so a frame is drained with frame_width+1 flush
// items in erode/dilate mode and 2*frame_width+2 in open/close mode.
// Throughput is one transaction per cycle on both sides unless one stalls;
// a result goes from the processing register into the output register.
// The line buffers are one RAM per stage with a registered read, addressed
// at accept time and written when the processing register fires.
// Configuration writes (i_cfg_valid / o_cfg_ready) go to registers 0..3:
// mask, mode, width, height. They wait for the processing register to
// empty, and input stalls while one is pending. A width or height write
// rebuilds the row and column of both stage positions with a bit-serial
// divider while input and config are held off.
// Reset restores mask 186, open mode, 640x480 and clears positions.
// When the receiver stalls, one result waits in the output register and
// one more item is held in the processing register before input stalls.
// ----------------------------------------------------------------------------
module binary_morphology_3x3
    import bm3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic                  i_frame_start,
    input  logic                  i_flush,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_last_pixel,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = CW + ROW_W;
    localparam int W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic [MASK_W-1:0]   r_mask;
    t_mode               r_mode;
    logic [WW-1:0]       r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [WW-1:0]       cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;
    logic                cfg_we;

    t_seq_state          r_state;
    t_seq_state          n_state;
    logic                div_start;
    logic                div_done;
    logic [PW-1:0]       div_quot;
    logic [WW-1:0]       div_rem;
    logic                load1;
    logic                load2;
    logic [PW-1:0]       pos1;
    logic [PW-1:0]       pos2;

    logic                accept;
    logic                two_now;
    logic                fg_now;
    logic                r_s1_valid;
    logic                r_s1_bit;
    logic                r_s1_two;
    logic                r_s1_first_erode;
    logic                s1_fire;
    logic                has_result;
    logic                res_bit;
    logic                res_last;
    logic                out_free;
    logic                offer2;

    t_stage_acc          acc1;
    t_stage_acc          acc2;
    t_stage_res          res1;
    t_stage_res          res2;

    logic                r_out_valid;
    logic [PIX_W-1:0]    r_out_pixel;
    logic                r_out_last;

    // ---------------- configuration ----------------
    assign cfg_we = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (i_cfg_data[10:0] < 11'(MIN_SIZE)) begin
            cfg_width = WW'(MIN_SIZE);
        end else if (32'(i_cfg_data[10:0]) > 32'(MAX_WIDTH)) begin
            cfg_width = WW'(MAX_WIDTH);
        end else begin
            cfg_width = WW'(i_cfg_data[10:0]);
        end
        cfg_height = (i_cfg_data < CFG_DATA_W'(MIN_SIZE)) ? HEIGHT_W'(MIN_SIZE) : i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= MASK_RESET;
            r_mode   <= MODE_OPEN;
            r_width  <= WW'(W_RESET);
            r_height <= HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_MASK:   r_mask   <= i_cfg_data[MASK_W-1:0];
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                CFG_WIDTH:  r_width  <= cfg_width;
                CFG_HEIGHT: r_height <= cfg_height;
                default: ;
            endcase
        end
    end

    // ---------------- position rebuild sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        load1     = 1'b0;
        load2     = 1'b0;
        unique case (r_state)
            SEQ_RUN: begin
                if (cfg_we && ((i_cfg_index == CFG_WIDTH) || (i_cfg_index == CFG_HEIGHT))) begin
                    n_state = SEQ_GO1;
                end
            end
            SEQ_GO1: begin
                div_start = 1'b1;
                n_state   = SEQ_WAIT1;
            end
            SEQ_WAIT1: begin
                if (div_done) begin
                    load1   = 1'b1;
                    n_state = SEQ_GO2;
                end
            end
            SEQ_GO2: begin
                div_start = 1'b1;
                n_state   = SEQ_WAIT2;
            end
            SEQ_WAIT2: begin
                if (div_done) begin
                    load2   = 1'b1;
                    n_state = SEQ_RUN;
                end
            end
            default: n_state = SEQ_RUN;
        endcase
    end

    // a write waits until no transaction sits in the processing register
    assign o_cfg_ready = (r_state == SEQ_RUN) && !r_s1_valid;

    bm3_div #(
        .DIVIDEND_W (PW),
        .DIVISOR_W  (WW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ((r_state == SEQ_GO2) ? pos2 : pos1),
        .i_divisor  (r_width),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // ---------------- accept and processing register ----------------
    assign out_free   = !r_out_valid || !i_out_stall;
    assign has_result = r_s1_two ? res2.emit : res1.emit;
    assign res_bit    = r_s1_two ? res2.bit_val : res1.bit_val;
    assign res_last   = r_s1_two ? res2.last : res1.last;
    assign s1_fire    = r_s1_valid && (!has_result || out_free);
    assign o_in_stall = (r_state != SEQ_RUN) || i_cfg_valid || (r_s1_valid && !s1_fire);
    assign accept     = i_in_valid && !o_in_stall;

    assign two_now = (r_mode == MODE_OPEN) || (r_mode == MODE_CLOSE);
    assign fg_now  = !i_flush && (i_pixel_in == FG_VALUE);
    // second stage takes every first-stage output, and background once the
    // first stage has stopped
    assign offer2  = accept && two_now && (acc1.emit || !acc1.take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_bit         <= fg_now;
            r_s1_two         <= two_now;
            r_s1_first_erode <= (r_mode == MODE_ERODE) || (r_mode == MODE_OPEN);
        end
    end

    bm3_stage #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_stage1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_capture   (accept),
        .i_offer     (accept),
        .i_restart   (i_frame_start),
        .o_acc       (acc1),
        .i_load      (load1),
        .i_load_quot (div_quot),
        .i_load_rem  (div_rem),
        .o_pos       (pos1),
        .i_fire      (s1_fire),
        .i_bit       (r_s1_bit),
        .i_erode     (r_s1_first_erode),
        .i_mask      (r_mask),
        .o_res       (res1)
    );

    bm3_stage #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_stage2 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_capture   (accept),
        .i_offer     (offer2),
        .i_restart   (i_frame_start),
        .o_acc       (acc2),
        .i_load      (load2),
        .i_load_quot (div_quot),
        .i_load_rem  (div_rem),
        .o_pos       (pos2),
        .i_fire      (s1_fire),
        .i_bit       (res1.emit && res1.bit_val),
        .i_erode     (!r_s1_first_erode),
        .i_mask      (r_mask),
        .o_res       (res2)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && has_result) begin
            r_out_pixel <= res_bit ? FG_VALUE : '0;
            r_out_last  <= res_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_out_pixel;
    assign o_last_pixel = r_out_last;

endmodule

/* tb/tb_binary_morphology_3x3.sv */
// ----------------------------------------------------------------------------
// tb_binary_morphology_3x3
// Self-checking testbench for the streaming 3x3 binary morphology block.
// A scoreboard class keeps its own two-stage line buffer and window model
// and predicts every output pixel from the accepted input transactions.
// Frames run in all four modes with random masks and sizes. Some frames
// are cut short or restarted, and some carry flush items inside the frame.
// A few frames are started at the widest and tallest sizes. Both sides insert
// random gaps, and the run ends on a watchdog if no transaction moves for too long.
// ----------------------------------------------------------------------------
module tb_binary_morphology_3x3
    import bm3_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W          = 1024;
    localparam int IDLE_MAX       = 6;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 450;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             last;
    } pixel_res_t;

    class morph_scoreboard;
        bit [MASK_W-1:0]   mask;
        t_mode             mode;
        bit [10:0]         width_reg;
        bit [HEIGHT_W-1:0] height_reg;
        bit                lines [2][2*MAX_W];
        bit [MASK_W-1:0]   win [2];
        int unsigned       pos [2];
        pixel_res_t        due_pixels [$];
        int unsigned       failures;
        int unsigned       matched;

        function new();
            mask       = MASK_RESET;
            mode       = MODE_OPEN;
            width_reg  = 11'(WIDTH_RESET);
            height_reg = HEIGHT_RESET;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MASK:   mask = data[MASK_W-1:0];
                CFG_MODE:   mode = t_mode'(data[1:0]);
                CFG_WIDTH:  width_reg = data[10:0];
                CFG_HEIGHT: height_reg = data;
            endcase
        endfunction

        function int unsigned eff_w();
            if (width_reg < MIN_SIZE) return MIN_SIZE;
            if (width_reg > MAX_W) return MAX_W;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            return (height_reg < MIN_SIZE) ? MIN_SIZE : height_reg;
        endfunction

        // one bit into a stage, returns 1 when the stage emits a pixel
        function bit push_stage(int s, bit b, bit erode, output bit ob, output bit lst);
            int unsigned w, h, total, p, c, q, qr, qc;
            bit top, mid;
            w     = eff_w();
            h     = eff_h();
            total = w * h;
            p     = pos[s];
            ob    = 1'b0;
            lst   = 1'b0;
            if (p >= total + w + 1) return 1'b0;
            c   = p % w;
            top = lines[s][MAX_W + c];
            mid = lines[s][c];
            lines[s][MAX_W + c] = mid;
            lines[s][c]         = b;
            win[s] = ((win[s] >> 1) & COL_KEEP) | {b, 2'b00, mid, 2'b00, top, 2'b00};
            pos[s] = p + 1;
            if (p < w + 1) return 1'b0;
            q  = p - w - 1;
            qr = q / w;
            qc = q % w;
            if (qr == 0 || qr >= h - 1 || qc == 0 || qc == w - 1) ob = 1'b0;
            else if (erode) ob = ((win[s] & mask) == mask);
            else ob = ((win[s] & mask) != '0);
            lst = (q == total - 1);
            return 1'b1;
        endfunction

        function void take_pixel(logic [PIX_W-1:0] pix, logic fs, logic fl);
            bit fg, first_erodes, first_done, have, b1, l1, res, lst;
            int unsigned w;
            fg           = !fl && (pix == FG_VALUE);
            first_erodes = (mode == MODE_ERODE || mode == MODE_OPEN);
            if (fs) begin
                pos[0] = 0;
                pos[1] = 0;
                win[0] = '0;
                win[1] = '0;
            end
            w          = eff_w();
            first_done = pos[0] >= w * eff_h() + w + 1;
            have       = push_stage(0, fg, first_erodes, b1, l1);
            res        = b1;
            lst        = l1;
            if (mode == MODE_OPEN || mode == MODE_CLOSE) begin
                // second stage sees background once the first has finished the frame
                if (have) have = push_stage(1, b1, !first_erodes, res, lst);
                else if (first_done) have = push_stage(1, 1'b0, !first_erodes, res, lst);
            end
            if (have) due_pixels.push_back(pixel_res_t'({res ? FG_VALUE : 8'h00, lst}));
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= REPORT_MAX) $display("%0t: %s", $time, msg);
        endfunction

        function void check_pixel(logic [PIX_W-1:0] pix, logic last);
            pixel_res_t want;
            if (due_pixels.size() == 0) begin
                note_failure($sformatf("unexpected result: pixel %0d last %0b", pix, last));
                return;
            end
            want = due_pixels.pop_front();
            if (want.pix !== pix || want.last !== last)
                note_failure($sformatf("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                                       want.pix, want.last, pix, last));
            else
                matched++;
        endfunction

        function void close_out();
            if (due_pixels.size() != 0)
                note_failure($sformatf("%0d expected pixels never came out", due_pixels.size()));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [PIX_W-1:0]      i_pixel_in;
    logic                  i_frame_start;
    logic                  i_flush;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_last_pixel;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    morph_scoreboard sb = new();
    int unsigned idle_cycles = 0;
    int unsigned out_hold = 0;
    bit          quiet = 1'b0;
    int unsigned frames_run = 0;
    int unsigned items_sent = 0;
    int unsigned widest = 0;
    int unsigned tallest = 0;
    bit [3:0]    modes_run = '0;

    binary_morphology_3x3 #(.MAX_WIDTH(MAX_W)) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            sb.check_pixel(o_pixel_out, o_last_pixel);
            out_hold = quiet ? 0 : $urandom_range(0, IDLE_MAX);
        end
        if (i_in_valid && !o_in_stall) sb.take_pixel(i_pixel_in, i_frame_start, i_flush);
        if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
        if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    // receiver holds off for a random number of cycles after each transaction
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold > 0) begin
                i_out_stall <= 1'b1;
                out_hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        do @(negedge i_clk); while (idle_cycles < WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic send_item(logic [PIX_W-1:0] pix, logic fs, logic fl);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, IDLE_MAX);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel_in    <= pix;
        i_frame_start <= fs;
        i_flush       <= fl;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sender pauses until every predicted pixel is out and the pipe is quiet
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.due_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(logic [MASK_W-1:0] mask, t_mode mode,
                             logic [CFG_DATA_W-1:0] width, logic [CFG_DATA_W-1:0] height);
        settle();
        write_cfg(CFG_MASK, {3'($urandom), mask});
        write_cfg(CFG_MODE, {10'($urandom), mode});
        write_cfg(CFG_WIDTH, width);
        write_cfg(CFG_HEIGHT, height);
        modes_run[mode] = 1'b1;
        if (sb.eff_w() > widest) widest = sb.eff_w();
        if (sb.eff_h() > tallest) tallest = sb.eff_h();
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel(int unsigned fg_pct);
        if ($urandom_range(0, 99) < fg_pct) return FG_VALUE;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return MASK_RESET;
            default: return MASK_W'($urandom);
        endcase
    endfunction

    task automatic send_drain();
        int unsigned n, len;
        len = (sb.mode == MODE_ERODE || sb.mode == MODE_DILATE) ? sb.eff_w() + 1
                                                               : 2 * sb.eff_w() + 2;
        for (n = 0; n < len; n++) send_item(rand_pixel(50), 1'b0, 1'b1);
        items_sent += len;
    endtask

    // cut != 0 stops the frame early so the next frame start lands mid-frame
    task automatic run_frame(int unsigned fg_pct, int unsigned cut, bit fs_flush);
        int unsigned n, n_pix;
        n_pix = sb.eff_w() * sb.eff_h();
        if (cut != 0 && cut < n_pix) n_pix = cut;
        for (n = 0; n < n_pix; n++) begin
            if (n == 0) send_item(rand_pixel(fg_pct), 1'b1, fs_flush);
            else send_item(rand_pixel(fg_pct), 1'b0, $urandom_range(0, 49) == 0);
        end
        items_sent += n_pix;
        if (cut == 0) send_drain();
        frames_run++;
    endtask

    initial begin
        int unsigned n, kind, fg_pct;
        logic [CFG_DATA_W-1:0] width_data;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_pixel_in    = '0;
        i_frame_start = 1'b0;
        i_flush       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_MASK;
        i_cfg_data    = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // solid frame under full-mask erosion, sizes below the minimum
        configure('1, MODE_ERODE, 12'd0, 12'd2);
        run_frame(100, 0, 1'b0);

        // closing with flush on the frame start and on the center pixel
        configure(MASK_RESET, MODE_CLOSE, 12'd3, 12'd3);
        for (n = 0; n < 9; n++) send_item(FG_VALUE, n == 0, n == 0 || n == 4);
        send_drain();
        frames_run++;
        // after the drain these produce nothing
        send_item(FG_VALUE, 1'b0, 1'b0);
        send_item(8'd0, 1'b0, 1'b1);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            width_data = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(11, 40))
                                                     : CFG_DATA_W'($urandom_range(0, 10));
            if ($urandom_range(0, 3) == 0) width_data[11] = 1'b1;
            configure(pick_mask(), t_mode'($urandom_range(0, 3)), width_data,
                      CFG_DATA_W'($urandom_range(0, 7)));
            quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                kind   = $urandom_range(0, 9);
                fg_pct = $urandom_range(40, 100);
                if (kind < 7) begin
                    run_frame(fg_pct, 0, $urandom_range(0, 9) == 0);
                end else if (kind < 9) begin
                    run_frame(fg_pct, $urandom_range(1, sb.eff_w() * sb.eff_h() - 1), 1'b0);
                end else begin
                    run_frame(fg_pct, 0, 1'b0);
                    repeat ($urandom_range(1, 4))
                        send_item(rand_pixel(fg_pct), 1'b0, $urandom_range(0, 1));
                end
            end
        end

        // width above the maximum clamps to the line buffer size, so a short
        // start of a frame at that width gives no result
        configure(pick_mask(), MODE_CLOSE, 12'd2047, 12'd3);
        quiet = $urandom_range(0, 1);
        run_frame(85, 40, 1'b0);
        // tallest frame is only started, then a small frame restarts the counters
        configure(pick_mask(), MODE_OPEN, 12'd3, 12'd4095);
        run_frame(90, 60, 1'b0);
        configure(pick_mask(), MODE_DILATE, 12'd5, 12'd4);
        quiet = 1'b0;
        run_frame(60, 0, 1'b0);

        settle();
        sb.close_out();
        $display("ran %0d frames, modes seen %b, sizes up to %0d wide and %0d tall",
                 frames_run, modes_run, widest, tallest);
        $display("%0d output pixels matched, %0d failures", sb.matched, sb.failures);
        if (sb.failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
